[rtl/tbics_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the two-branch inverse-CDF sampler.
package tbics_pkg;

  localparam int MAX_BINS  = 1024;
  localparam int IDX_W     = $clog2(MAX_BINS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int PFX_W     = 42;
  localparam int LA_W      = 32;
  localparam int BW_W      = 33;
  localparam int OUT_IDX_W = 10;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one table row: prefix sum, LA weight, bin weight (LA + TA)
  typedef struct packed {
    logic [PFX_W-1:0] prefix;
    logic [LA_W-1:0]  la;
    logic [BW_W-1:0]  weight;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // midpoint of a bisection interval, rounded down
  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                              input logic [IDX_W-1:0] hi);
    logic [IDX_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[IDX_W:1];
  endfunction

endpackage

[rtl/tbics_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sampler's input and result items.
interface tbics_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] la_weight;
  logic [31:0] ta_weight;
  logic [31:0] rand_bin;
  logic [31:0] rand_branch;

  modport source (output valid, opcode, la_weight, ta_weight, rand_bin, rand_branch,
                  input ready);
  modport sink (input valid, opcode, la_weight, ta_weight, rand_bin, rand_branch,
                output ready);
endinterface

interface tbics_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] bin_index;
  logic       branch_is_la;
  logic [1:0] status;

  modport source (output valid, bin_index, branch_is_la, status, input ready);
  modport sink (input valid, bin_index, branch_is_la, status, output ready);
endinterface

[rtl/tbics_table.sv]
`timescale 1ns / 1ps
// Bin table memory: one write port, one read port with registered read data.
module tbics_table import tbics_pkg::*; (
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data_r
);

  entry_t mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

[rtl/tbics_mul.sv]
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with a registered product.
module tbics_mul import tbics_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, a} * {32'd0, b};
  end

endmodule

[rtl/two_branch_inverse_cdf_sampler.sv]
`timescale 1ns / 1ps
// Two-branch discrete inverse-CDF sampler: a table of up to MAX_BINS bins, each holding its
// running prefix sum, LA weight and total weight, in one synchronous memory. A clear item
// empties the table, an append item adds one bin (status FULL when the table is full), and a
// sample item picks the smallest bin whose prefix exceeds floor(rand_bin * total / 2^32) by
// bisection, then picks the LA branch when rand_branch * bin_weight <= la_weight * 2^32
// (status EMPTY on an empty table). Every item gives exactly one result item. Items are
// handled one at a time: clear, append and unused opcodes go from acceptance straight to
// the done state; a sample first runs the multiply states, the bisection probes, the fetch
// of the picked bin and the branch test. Either way the result then waits in the done state
// until the output register is empty or being read, and moves into it from there.
// The sample time is set by the single memory read port, which probes one prefix per cycle,
// plus three passes through the one shared 32x32 multiplier (two for the 32x42 threshold
// product, one for the branch test). A new item is taken while the previous result still
// waits in the output register. The table has no reset; only entries below the bin count
// are ever read, and a sample never writes, so no read/write overlap arises.
module two_branch_inverse_cdf_sampler import tbics_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tbics_in_if.sink    in_ch,
  tbics_out_if.source out_ch
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL0  = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_MUL2  = 8'b0000_1000,
    S_SRCH  = 8'b0001_0000,
    S_FETCH = 8'b0010_0000,
    S_BR    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   bin_count_r, bin_count_nxt;
  logic [PFX_W-1:0]   running_total_r, running_total_nxt;
  logic               out_valid_r, out_valid_nxt;

  // item payload and datapath registers
  logic [31:0]        r1_r, r1_nxt;
  logic [31:0]        r2_r, r2_nxt;
  logic [IDX_W-1:0]   lo_r, lo_nxt;
  logic [IDX_W-1:0]   hi_r, hi_nxt;
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic [PFX_W-1:0]   h_r, h_nxt;
  logic [31:0]        plo_hi_r, plo_hi_nxt;
  logic [LA_W-1:0]    la_r, la_nxt;
  logic               w_hi_r, w_hi_nxt;
  logic [OUT_IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic               res_la_r, res_la_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_la_r, out_la_nxt;
  status_t            out_status_r, out_status_nxt;

  // memory and multiplier hookup
  tbl_wr_t            tbl_wr;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data_r;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_r;

  // append arithmetic
  logic [BW_W-1:0]    wsum;
  logic [PFX_W:0]     tot_ext;
  logic [PFX_W-1:0]   tot_sat;

  // search step and branch test
  logic [IDX_W-1:0]   lo_s, hi_s;
  logic [64:0]        br_full;
  logic               accept, out_load;

  tbics_table u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  tbics_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.bin_index    = out_idx_r;
  assign out_ch.branch_is_la = out_la_r;
  assign out_ch.status       = out_status_r;

  // weight of a new bin and saturated running total
  assign wsum    = {1'b0, in_ch.la_weight} + {1'b0, in_ch.ta_weight};
  assign tot_ext = {1'b0, running_total_r} + (PFX_W + 1)'(wsum);
  assign tot_sat = tot_ext[PFX_W] ? {PFX_W{1'b1}} : tot_ext[PFX_W-1:0];

  // one bisection step on the prefix just read at mid_r
  always_comb begin
    lo_s = lo_r;
    hi_s = hi_r;
    if (rd_data_r.prefix > h_r) begin
      hi_s = mid_r;
    end else begin
      lo_s = mid_r + 1'b1;
    end
  end

  // r2 * weight: low 32 weight bits from the multiplier, top bit added as a shift
  assign br_full = {1'b0, prod_r} + (w_hi_r ? {1'b0, r2_r, 32'd0} : 65'd0);

  // multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = r1_r;
        mul_b = {22'd0, running_total_r[PFX_W-1:32]};
      end
      S_FETCH: begin
        mul_a = r2_r;
        mul_b = rd_data_r.weight[31:0];
      end
      default: begin
        mul_a = r1_r;
        mul_b = running_total_r[31:0];
      end
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    bin_count_nxt     = bin_count_r;
    running_total_nxt = running_total_r;
    r1_nxt            = r1_r;
    r2_nxt            = r2_r;
    lo_nxt            = lo_r;
    hi_nxt            = hi_r;
    mid_nxt           = mid_r;
    h_nxt             = h_r;
    plo_hi_nxt        = plo_hi_r;
    la_nxt            = la_r;
    w_hi_nxt          = w_hi_r;
    res_idx_nxt       = res_idx_r;
    res_la_nxt        = res_la_r;
    res_status_nxt    = res_status_r;
    rd_addr           = lo_r;
    tbl_wr.en         = 1'b0;
    tbl_wr.addr       = bin_count_r[IDX_W-1:0];
    tbl_wr.data       = '{prefix: tot_sat, la: in_ch.la_weight, weight: wsum};
    out_load          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_idx_nxt    = '0;
          res_la_nxt     = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          case (in_ch.opcode)
            OP_CLEAR: begin
              bin_count_nxt     = '0;
              running_total_nxt = '0;
            end
            OP_APPEND: begin
              if (bin_count_r >= CNT_W'(MAX_BINS)) begin
                res_status_nxt = ST_FULL;
              end else begin
                tbl_wr.en         = 1'b1;
                running_total_nxt = tot_sat;
                bin_count_nxt     = bin_count_r + 1'b1;
              end
            end
            OP_SAMPLE: begin
              if (bin_count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                r1_nxt    = in_ch.rand_bin;
                r2_nxt    = in_ch.rand_branch;
                lo_nxt    = '0;
                hi_nxt    = IDX_W'(bin_count_r - 1'b1);
                state_nxt = S_MUL0;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL0: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        plo_hi_nxt = prod_r[63:32];
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        // threshold h = floor(r1 * total / 2^32); first probe issued alongside
        h_nxt = prod_r[PFX_W-1:0] + PFX_W'(plo_hi_r);
        if (lo_r < hi_r) begin
          mid_nxt   = mid_of(lo_r, hi_r);
          rd_addr   = mid_nxt;
          state_nxt = S_SRCH;
        end else begin
          rd_addr   = lo_r;
          state_nxt = S_FETCH;
        end
      end
      S_SRCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          mid_nxt = mid_of(lo_s, hi_s);
          rd_addr = mid_nxt;
        end else begin
          rd_addr   = lo_s;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        la_nxt    = rd_data_r.la;
        w_hi_nxt  = rd_data_r.weight[BW_W-1];
        state_nxt = S_BR;
      end
      S_BR: begin
        res_idx_nxt = OUT_IDX_W'(lo_r);
        res_la_nxt  = (br_full <= {1'b0, la_r, 32'd0});
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_idx_nxt    = out_idx_r;
    out_la_nxt     = out_la_r;
    out_status_nxt = out_status_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_idx_nxt    = res_idx_r;
      out_la_nxt     = res_la_r;
      out_status_nxt = res_status_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      bin_count_r     <= '0;
      running_total_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      bin_count_r     <= bin_count_nxt;
      running_total_r <= running_total_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r1_r         <= r1_nxt;
    r2_r         <= r2_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    h_r          <= h_nxt;
    plo_hi_r     <= plo_hi_nxt;
    la_r         <= la_nxt;
    w_hi_r       <= w_hi_nxt;
    res_idx_r    <= res_idx_nxt;
    res_la_r     <= res_la_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_la_r     <= out_la_nxt;
    out_status_r <= out_status_nxt;
  end

  // table never holds more than MAX_BINS bins
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bin_count_r <= CNT_W'(MAX_BINS))
    else $error("bin count beyond table size");

  // a bisection interval stays open and inside the filled part of the table
  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (lo_r < hi_r) && ({1'b0, hi_r} < bin_count_r))
    else $error("bisection interval out of range");

  // error results carry no bin and no branch
  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_idx_r == '0) && !out_la_r)
    else $error("error result with nonzero payload");

  // a sample never starts on an empty table
  a_sample_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL0) |-> (bin_count_r != '0))
    else $error("sample search on empty table");

endmodule
